/* hdl/vksd_pkg.sv */
package vksd_pkg;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       more_pending;
    } t_rx;

    typedef struct packed {
        logic [2:0] key_kind;
        logic [7:0] key_value;
    } t_key;

    localparam logic [7:0] C_ESC      = 8'h1B;
    localparam logic [7:0] C_LBRACKET = 8'h5B;
    localparam logic [7:0] C_LETTER_O = 8'h4F;
    localparam logic [7:0] C_TILDE    = 8'h7E;
    localparam logic [7:0] C_ZERO     = 8'h30;
    localparam logic [7:0] C_ONE      = 8'h31;
    localparam logic [7:0] C_TWO      = 8'h32;
    localparam logic [7:0] C_SIX      = 8'h36;
    localparam logic [7:0] C_NINE     = 8'h39;
    localparam logic [7:0] C_UPPER_A  = 8'h41;
    localparam logic [7:0] C_UPPER_D  = 8'h44;
    localparam logic [7:0] C_UPPER_F  = 8'h46;
    localparam logic [7:0] C_UPPER_H  = 8'h48;
    localparam logic [7:0] C_UPPER_P  = 8'h50;
    localparam logic [7:0] C_UPPER_Q  = 8'h51;
    localparam logic [7:0] C_UPPER_R  = 8'h52;
    localparam logic [7:0] C_UPPER_S  = 8'h53;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_ESC     = 4'd1;
    localparam logic [3:0] ST_BRACKET = 4'd2;
    localparam logic [3:0] ST_O       = 4'd3;
    localparam logic [3:0] ST_DIGIT1  = 4'd4;
    localparam logic [3:0] ST_DIGIT6  = 4'd9;
    localparam logic [3:0] ST_FUNC2   = 4'd10;

    localparam logic [2:0] KIND_CHAR   = 3'd0;
    localparam logic [2:0] KIND_CURSOR = 3'd1;
    localparam logic [2:0] KIND_OKEY   = 3'd2;
    localparam logic [2:0] KIND_EDIT   = 3'd3;
    localparam logic [2:0] KIND_FUNC   = 3'd4;
    localparam logic [2:0] KIND_BAD    = 3'd5;

    localparam logic [1:0] FD_NONE = 2'd0;
    localparam logic [1:0] FD_ONE  = 2'd1;
    localparam logic [1:0] FD_TWO  = 2'd2;

    localparam logic [5:0] FUNC_BELOW = 6'd10;
    localparam logic [5:0] FUNC_ABOVE = 6'd25;

endpackage

/* hdl/vksd_in_stage.sv */
module vksd_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  vksd_pkg::t_rx   i_rx,
    output logic            o_valid,
    input  logic            i_take,
    output vksd_pkg::t_rx   o_rx
);

    logic          r_valid;
    logic          n_valid;
    vksd_pkg::t_rx r_rx;

    assign o_ready = !r_valid || i_take;
    assign n_valid = (i_valid && o_ready) || (r_valid && !i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_rx <= i_rx;
        end
    end

    assign o_valid = r_valid;
    assign o_rx    = r_rx;

endmodule

/* hdl/vksd_decode.sv */
module vksd_decode (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  vksd_pkg::t_rx   i_rx,
    output logic            o_emit,
    output vksd_pkg::t_key  o_key
);

    logic [3:0]     r_state;
    logic [1:0]     r_first_digit;
    logic [3:0]     r_second_digit;
    logic [3:0]     n_state;
    logic [1:0]     n_first_digit;
    logic [3:0]     n_second_digit;
    logic           emit;
    vksd_pkg::t_key key;
    logic [7:0]     c;
    logic [5:0]     fx;
    logic           is_digit;

    assign c        = i_rx.rx_byte;
    assign fx       = 6'(r_first_digit) * 6'd10 + 6'(r_second_digit);
    assign is_digit = (c >= vksd_pkg::C_ZERO) && (c <= vksd_pkg::C_NINE);

    always_comb begin
        n_state        = r_state;
        n_first_digit  = r_first_digit;
        n_second_digit = r_second_digit;
        emit           = 1'b0;
        key.key_kind   = vksd_pkg::KIND_BAD;
        key.key_value  = 8'd0;

        priority if (c == vksd_pkg::C_ESC && i_rx.more_pending) begin
            n_state = vksd_pkg::ST_ESC;
        end else if (r_state == vksd_pkg::ST_ESC) begin
            priority if (c == vksd_pkg::C_LBRACKET) begin
                n_state = vksd_pkg::ST_BRACKET;
            end else if (c == vksd_pkg::C_LETTER_O) begin
                n_state = vksd_pkg::ST_O;
            end else begin
                emit = 1'b1;
            end
        end else if (r_state == vksd_pkg::ST_BRACKET) begin
            priority if (c >= vksd_pkg::C_UPPER_A && c <= vksd_pkg::C_UPPER_D) begin
                emit          = 1'b1;
                key.key_kind  = vksd_pkg::KIND_CURSOR;
                key.key_value = c - vksd_pkg::C_UPPER_A;
            end else if (c >= vksd_pkg::C_ONE && c <= vksd_pkg::C_SIX) begin
                n_state = vksd_pkg::ST_DIGIT1 + 4'(c - vksd_pkg::C_ONE);
                if (c == vksd_pkg::C_ONE) begin
                    n_first_digit = vksd_pkg::FD_ONE;
                end else if (c == vksd_pkg::C_TWO) begin
                    n_first_digit = vksd_pkg::FD_TWO;
                end
            end else begin
                emit = 1'b1;
            end
        end else if (r_state == vksd_pkg::ST_O) begin
            emit         = 1'b1;
            key.key_kind = vksd_pkg::KIND_OKEY;
            unique case (c)
                vksd_pkg::C_UPPER_P: key.key_value = 8'd0;
                vksd_pkg::C_UPPER_Q: key.key_value = 8'd1;
                vksd_pkg::C_UPPER_R: key.key_value = 8'd2;
                vksd_pkg::C_UPPER_S: key.key_value = 8'd3;
                vksd_pkg::C_UPPER_H: key.key_value = 8'd4;
                vksd_pkg::C_UPPER_F: key.key_value = 8'd5;
                default: begin
                    key.key_kind  = vksd_pkg::KIND_BAD;
                    key.key_value = 8'd0;
                end
            endcase
        end else if (r_state >= vksd_pkg::ST_DIGIT1 && r_state <= vksd_pkg::ST_DIGIT6) begin
            priority if (c == vksd_pkg::C_TILDE) begin
                emit          = 1'b1;
                key.key_kind  = vksd_pkg::KIND_EDIT;
                key.key_value = 8'(r_state - vksd_pkg::ST_DIGIT1 + 4'd1);
            end else if (is_digit && (r_first_digit == vksd_pkg::FD_ONE
                                      || r_first_digit == vksd_pkg::FD_TWO)) begin
                n_state        = vksd_pkg::ST_FUNC2;
                n_second_digit = 4'(c - vksd_pkg::C_ZERO);
            end else begin
                emit = 1'b1;
            end
        end else if (r_state == vksd_pkg::ST_FUNC2) begin
            emit = 1'b1;
            if (c == vksd_pkg::C_TILDE && fx > vksd_pkg::FUNC_BELOW
                && fx < vksd_pkg::FUNC_ABOVE) begin
                key.key_kind  = vksd_pkg::KIND_FUNC;
                key.key_value = 8'(fx);
            end
        end else begin
            emit          = 1'b1;
            key.key_kind  = vksd_pkg::KIND_CHAR;
            key.key_value = c;
        end

        if (emit) begin
            n_state        = vksd_pkg::ST_IDLE;
            n_first_digit  = vksd_pkg::FD_NONE;
            n_second_digit = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= vksd_pkg::ST_IDLE;
            r_first_digit  <= vksd_pkg::FD_NONE;
            r_second_digit <= 4'd0;
        end else if (i_fire) begin
            r_state        <= n_state;
            r_first_digit  <= n_first_digit;
            r_second_digit <= n_second_digit;
        end
    end

    assign o_emit = emit;
    assign o_key  = key;

    a_fd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_first_digit != 2'd3)
        else $error("first digit holds an impossible code");

    a_func_has_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == vksd_pkg::ST_FUNC2 |-> (r_first_digit == vksd_pkg::FD_ONE
                                           || r_first_digit == vksd_pkg::FD_TWO))
        else $error("second function digit without a first digit");

    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && emit |=> r_state == vksd_pkg::ST_IDLE
                           && r_first_digit == vksd_pkg::FD_NONE
                           && r_second_digit == 4'd0)
        else $error("result did not clear the parser");

    a_sd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second_digit <= 4'd9)
        else $error("second digit out of range");

endmodule

/* hdl/vksd_out_stage.sv */
module vksd_out_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    output logic            o_can_load,
    input  vksd_pkg::t_key  i_key,
    output logic            o_valid,
    input  logic            i_ready,
    output vksd_pkg::t_key  o_key
);

    logic           r_valid;
    logic           n_valid;
    vksd_pkg::t_key r_key;

    assign o_can_load = !r_valid || i_ready;
    assign n_valid    = i_load || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_key <= i_key;
        end
    end

    assign o_valid = r_valid;
    assign o_key   = r_key;

endmodule

/* hdl/vt100_key_sequence_decoder_top.sv */
// channel  valid         ready         payload
// in       i_in_valid    o_in_ready    i_rx_byte, i_more_pending
// out      o_out_valid   i_out_ready   o_key_kind, o_key_value
//
// one byte per cycle sustained unless the output stalls
// path: input register, combinational parser decode, result register
// synchronous active-low reset returns the parser to idle and empties both registers
// a stalled output holds the result; the input keeps taking bytes until both registers fill
module vt100_key_sequence_decoder_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_more_pending,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_key_kind,
    output logic [7:0] o_key_value
);

    vksd_pkg::t_rx  rx_in;
    vksd_pkg::t_rx  rx_q;
    vksd_pkg::t_key key_d;
    vksd_pkg::t_key key_q;
    logic           rx_valid;
    logic           can_load;
    logic           fire;
    logic           emit;

    assign rx_in.rx_byte      = i_rx_byte;
    assign rx_in.more_pending = i_more_pending;
    assign fire               = rx_valid && can_load;

    vksd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_rx    (rx_in),
        .o_valid (rx_valid),
        .i_take  (fire),
        .o_rx    (rx_q)
    );

    vksd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_rx    (rx_q),
        .o_emit  (emit),
        .o_key   (key_d)
    );

    vksd_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (fire && emit),
        .o_can_load (can_load),
        .i_key      (key_d),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_key      (key_q)
    );

    assign o_key_kind  = key_q.key_kind;
    assign o_key_value = key_q.key_value;

endmodule
